// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL of the dual-wheel PID unit.
// Depends on nothing; the macros expand to nothing when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define ASSERT_HOLDS(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("Assertion failed.");

`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("Assertion failed.");

`else

`define ASSERT_HOLDS(lbl, clk, rstn, prop)

`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// ----- rtl/dwip_pkg.sv -----
// Types, constants and helper functions of the dual-wheel PID unit.
// Depends on nothing; used by every module of the block.
package dwip_pkg;

    localparam int SPEED_BITS     = 16;
    localparam int GAIN_FRAC_BITS = 12;

    localparam int IN_BITS   = 16;
    localparam int GAIN_BITS = 16;
    localparam int PWM_BITS  = 11;
    localparam int CFG_BITS  = 16;
    localparam int IDX_BITS  = 3;

    localparam int ERR_BITS  = SPEED_BITS + 1;
    localparam int ACC_BITS  = PWM_BITS + GAIN_FRAC_BITS;
    localparam int PROD_BITS = GAIN_BITS + 1 + ERR_BITS + 2;
    localparam int INC_BITS  = PROD_BITS + 2;

    localparam int SYNC_DIV   = 4;
    localparam int SYNC_SHIFT = $clog2(SYNC_DIV);

    localparam longint GAIN_MAX    = (64'd1 << GAIN_BITS) - 1;
    localparam longint GP_RAW      = (64'd1 << GAIN_FRAC_BITS);
    localparam longint GI_RAW      = ((64'd8 << GAIN_FRAC_BITS) + 50) / 100;
    localparam longint GD_RAW      = ((64'd5 << GAIN_FRAC_BITS) + 50) / 100;
    localparam logic [GAIN_BITS-1:0] GAIN_P_RESET =
        GAIN_BITS'((GP_RAW > GAIN_MAX) ? GAIN_MAX : GP_RAW);
    localparam logic [GAIN_BITS-1:0] GAIN_I_RESET =
        GAIN_BITS'((GI_RAW > GAIN_MAX) ? GAIN_MAX : GI_RAW);
    localparam logic [GAIN_BITS-1:0] GAIN_D_RESET =
        GAIN_BITS'((GD_RAW > GAIN_MAX) ? GAIN_MAX : GD_RAW);
    localparam logic [PWM_BITS-1:0] PWM_CEIL_RESET  = PWM_BITS'(1999);
    localparam logic [PWM_BITS-1:0] PWM_FLOOR_RESET = PWM_BITS'(30);

    localparam logic signed [IN_BITS:0] SPEED_MAX = (IN_BITS+1)'((2**(SPEED_BITS-1)) - 1);
    localparam logic signed [IN_BITS:0] SPEED_MIN = (IN_BITS+1)'(-(2**(SPEED_BITS-1)));
    localparam logic signed [IN_BITS:0] ERR_MAX   = (IN_BITS+1)'((2**(ERR_BITS-1)) - 1);
    localparam logic signed [IN_BITS:0] ERR_MIN   = (IN_BITS+1)'(-(2**(ERR_BITS-1)));

    typedef logic signed [IN_BITS-1:0]  speed_t;
    typedef logic signed [ERR_BITS-1:0] err_t;
    typedef logic [GAIN_BITS-1:0]       gain_t;
    typedef logic [PWM_BITS-1:0]        pwm_t;
    typedef logic [ACC_BITS-1:0]        acc_t;

    typedef enum logic [IDX_BITS-1:0] {
        REG_GAIN_P      = 3'd0,
        REG_GAIN_I      = 3'd1,
        REG_GAIN_D      = 3'd2,
        REG_PWM_CEILING = 3'd3,
        REG_PWM_FLOOR   = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        gain_t gain_p;
        gain_t gain_i;
        gain_t gain_d;
        pwm_t  pwm_ceiling;
        pwm_t  pwm_floor;
    } lane_cfg_t;

    function automatic speed_t sat_speed(input logic signed [IN_BITS:0] v);
        speed_t r;
        if (v > SPEED_MAX)
        begin
            r = IN_BITS'(SPEED_MAX);
        end
        else if (v < SPEED_MIN)
        begin
            r = IN_BITS'(SPEED_MIN);
        end
        else
        begin
            r = IN_BITS'(v);
        end
        return r;
    endfunction

    function automatic err_t sat_err(input logic signed [IN_BITS:0] v);
        err_t r;
        if (v > ERR_MAX)
        begin
            r = ERR_BITS'(ERR_MAX);
        end
        else if (v < ERR_MIN)
        begin
            r = ERR_BITS'(ERR_MIN);
        end
        else
        begin
            r = ERR_BITS'(v);
        end
        return r;
    endfunction

endpackage

// ----- rtl/dwip_sync.sv -----
// Wheel synchronisation: saturates the speeds and skews the common target per wheel.
// Depends on dwip_pkg.
module dwip_sync
    import dwip_pkg::*;
(
    input  speed_t speed_setpoint,
    input  speed_t left_speed,
    input  speed_t right_speed,
    output speed_t left_target,
    output speed_t right_target,
    output speed_t left_actual,
    output speed_t right_actual
);

    speed_t                    tgt_sat;
    logic signed [IN_BITS:0]   diff;
    logic signed [IN_BITS:0]   adj;
    logic signed [IN_BITS:0]   tgt_ext;

    always_comb
    begin
        tgt_sat      = sat_speed({speed_setpoint[IN_BITS-1], speed_setpoint});
        left_actual  = sat_speed({left_speed[IN_BITS-1], left_speed});
        right_actual = sat_speed({right_speed[IN_BITS-1], right_speed});
        diff = {left_actual[IN_BITS-1], left_actual} - {right_actual[IN_BITS-1], right_actual};
        // Division by a power of two truncating towards zero.
        if (diff < 0)
        begin
            adj = (diff + (IN_BITS+1)'(SYNC_DIV - 1)) >>> SYNC_SHIFT;
        end
        else
        begin
            adj = diff >>> SYNC_SHIFT;
        end
        tgt_ext      = {tgt_sat[IN_BITS-1], tgt_sat};
        left_target  = sat_speed(tgt_ext - adj);
        right_target = sat_speed(tgt_ext + adj);
    end

endmodule

// ----- rtl/dwip_lane.sv -----
// One incremental PID lane: error history, clamped accumulator and PWM floor.
// Depends on dwip_pkg and assert_macros.svh.
`include "assert_macros.svh"

module dwip_lane
    import dwip_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      en,
    input  lane_cfg_t cfg,
    input  speed_t    target,
    input  speed_t    actual,
    output pwm_t      pwm
);

    acc_t acc_reg, acc_next;
    err_t e1_reg;
    err_t e2_reg;
    err_t err;

    logic signed [ERR_BITS:0]    d1;
    logic signed [ERR_BITS+1:0]  d2;
    logic signed [GAIN_BITS:0]   gp_s, gi_s, gd_s;
    logic signed [PROD_BITS-1:0] prod_p, prod_i, prod_d;
    logic signed [INC_BITS-1:0]  inc;
    logic signed [INC_BITS:0]    sum;
    logic signed [INC_BITS:0]    acc_top;
    pwm_t                        pwm_raw;

    always_comb
    begin
        err  = sat_err({target[IN_BITS-1], target} - {actual[IN_BITS-1], actual});
        d1   = {err[ERR_BITS-1], err} - {e1_reg[ERR_BITS-1], e1_reg};
        d2   = {{2{err[ERR_BITS-1]}}, err} - ({{2{e1_reg[ERR_BITS-1]}}, e1_reg} <<< 1)
             + {{2{e2_reg[ERR_BITS-1]}}, e2_reg};
        gp_s = $signed({1'b0, cfg.gain_p});
        gi_s = $signed({1'b0, cfg.gain_i});
        gd_s = $signed({1'b0, cfg.gain_d});
        prod_p = PROD_BITS'(gp_s) * PROD_BITS'(d1);
        prod_i = PROD_BITS'(gi_s) * PROD_BITS'(err);
        prod_d = PROD_BITS'(gd_s) * PROD_BITS'(d2);
        inc = INC_BITS'(prod_p) + INC_BITS'(prod_i) + INC_BITS'(prod_d);
        sum = (INC_BITS+1)'($signed({1'b0, acc_reg})) + (INC_BITS+1)'(inc);
        acc_top = (INC_BITS+1)'($signed({1'b0, cfg.pwm_ceiling, {GAIN_FRAC_BITS{1'b0}}}));
        if (sum > acc_top)
        begin
            acc_next = acc_top[ACC_BITS-1:0];
        end
        else if (sum < 0)
        begin
            acc_next = '0;
        end
        else
        begin
            acc_next = sum[ACC_BITS-1:0];
        end
        pwm_raw = acc_next[ACC_BITS-1:GAIN_FRAC_BITS];
        if ((pwm_raw != '0) && (pwm_raw < cfg.pwm_floor))
        begin
            pwm = cfg.pwm_floor;
        end
        else
        begin
            pwm = pwm_raw;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
            e1_reg  <= '0;
            e2_reg  <= '0;
        end
        else if (en)
        begin
            acc_reg <= acc_next;
            e1_reg  <= err;
            e2_reg  <= e1_reg;
        end
    end

    `ASSERT_NEXT(a_hist_shift, clk, rst_n, en, e2_reg == $past(e1_reg))
    `ASSERT_NEXT(a_hist_err, clk, rst_n, en, e1_reg == $past(err))
    `ASSERT_NEXT(a_acc_hold, clk, rst_n, !en, $stable(acc_reg) && $stable(e1_reg))

endmodule

// ----- rtl/dual_wheel_incremental_pid_unit.sv -----
// Top level of the dual-wheel incremental PID unit with its configuration registers.
// Depends on dwip_pkg, dwip_sync, dwip_lane and assert_macros.svh.
//
// Each transaction on the input channel is one control tick and yields exactly one
// transaction on the output channel carrying both PWM values. A tick is captured in an
// input register, worked through the synchronisation logic and both PID lanes, and
// lands in the output register; one tick can be accepted every cycle unless in_stall
// is raised. The per-lane accumulator and error history update once per tick, as the
// result is loaded into the output register. The input register keeps accepting while
// a finished result waits to be taken; the input is stalled only when both registers
// are full and the output is stalled. Configuration is written through cfg_wr_en,
// cfg_index and cfg_data by the user only while idle; the block does not enforce this.
`include "assert_macros.svh"

module dual_wheel_incremental_pid_unit
    import dwip_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [IDX_BITS-1:0] cfg_index,
    input  logic [CFG_BITS-1:0] cfg_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  speed_t              speed_setpoint,
    input  speed_t              left_speed,
    input  speed_t              right_speed,
    output logic                out_valid,
    input  logic                out_stall,
    output pwm_t                pwm_left,
    output pwm_t                pwm_right
);

    lane_cfg_t cfg_reg;
    logic      s1_valid_reg, s1_valid_next;
    logic      out_valid_reg, out_valid_next;
    speed_t    tgt_reg, left_reg, right_reg;
    pwm_t      pwm_left_reg, pwm_right_reg;
    logic      in_take;
    logic      out_load;
    speed_t    left_target, right_target, left_actual, right_actual;
    pwm_t      pwm_left_calc, pwm_right_calc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain_p      <= GAIN_P_RESET;
            cfg_reg.gain_i      <= GAIN_I_RESET;
            cfg_reg.gain_d      <= GAIN_D_RESET;
            cfg_reg.pwm_ceiling <= PWM_CEIL_RESET;
            cfg_reg.pwm_floor   <= PWM_FLOOR_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_GAIN_P:      cfg_reg.gain_p      <= cfg_data[GAIN_BITS-1:0];
                REG_GAIN_I:      cfg_reg.gain_i      <= cfg_data[GAIN_BITS-1:0];
                REG_GAIN_D:      cfg_reg.gain_d      <= cfg_data[GAIN_BITS-1:0];
                REG_PWM_CEILING: cfg_reg.pwm_ceiling <= cfg_data[PWM_BITS-1:0];
                REG_PWM_FLOOR:   cfg_reg.pwm_floor   <= cfg_data[PWM_BITS-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        out_load = s1_valid_reg && (!out_valid_reg || !out_stall);
        in_stall = s1_valid_reg && out_valid_reg && out_stall;
        in_take  = in_valid && !in_stall;

        if (in_take)
        begin
            s1_valid_next = 1'b1;
        end
        else if (out_load)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            tgt_reg   <= speed_setpoint;
            left_reg  <= left_speed;
            right_reg <= right_speed;
        end
        if (out_load)
        begin
            pwm_left_reg  <= pwm_left_calc;
            pwm_right_reg <= pwm_right_calc;
        end
    end

    dwip_sync u_sync (
        .speed_setpoint (tgt_reg),
        .left_speed     (left_reg),
        .right_speed    (right_reg),
        .left_target    (left_target),
        .right_target   (right_target),
        .left_actual    (left_actual),
        .right_actual   (right_actual)
    );

    dwip_lane u_lane_left (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (out_load),
        .cfg    (cfg_reg),
        .target (left_target),
        .actual (left_actual),
        .pwm    (pwm_left_calc)
    );

    dwip_lane u_lane_right (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (out_load),
        .cfg    (cfg_reg),
        .target (right_target),
        .actual (right_actual),
        .pwm    (pwm_right_calc)
    );

    assign out_valid = out_valid_reg;
    assign pwm_left  = pwm_left_reg;
    assign pwm_right = pwm_right_reg;

    `ASSERT_HOLDS(a_no_stall_when_out_empty, clk, rst_n, !out_valid_reg |-> !in_stall)
    `ASSERT_NEXT(a_take_fills_s1, clk, rst_n, in_take, s1_valid_reg)
    `ASSERT_HOLDS(a_out_from_s1, clk, rst_n, $rose(out_valid_reg) |-> $past(s1_valid_reg))

endmodule

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench for dual_wheel_incremental_pid_unit: a scoreboard class predicts
// both wheel PWM values per control tick and tasks drive ticks and register writes.
// Depends on dwip_pkg and the RTL of the unit.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import dwip_pkg::*;

    localparam int PIPE_SLACK     = 4;
    localparam int LONG_HOLD      = 80;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int PROBE_COUNT    = 20;

    localparam speed_t SPEED_TOP    = 16'sh7FFF;
    localparam speed_t SPEED_BOTTOM = 16'sh8000;
    localparam logic [IDX_BITS-1:0] FIRST_UNUSED_REG = IDX_BITS'(REG_PWM_FLOOR) + 1'b1;

    class pwm_tracker;
        gain_t kp;
        gain_t ki;
        gain_t kd;
        pwm_t  ceiling;
        pwm_t  floor_lvl;
        acc_t  acc [2];
        err_t  e_last [2];
        err_t  e_prev [2];
        pwm_t  due_left [$];
        pwm_t  due_right [$];
        int    ticks;
        int    checked;
        int    mismatches;

        function new();
            kp = 16'd4096;
            ki = 16'd328;
            kd = 16'd205;
            ceiling = 11'd1999;
            floor_lvl = 11'd30;
            for (int w = 0; w < 2; w++)
            begin
                acc[w] = '0;
                e_last[w] = '0;
                e_prev[w] = '0;
            end
            ticks = 0;
            checked = 0;
            mismatches = 0;
        endfunction

        function int pending();
            return due_left.size();
        endfunction

        function longint clamp_signed(longint v, int bits);
            longint hi;
            longint lo;
            hi = (longint'(1) << (bits - 1)) - 1;
            lo = -hi - 1;
            if (v > hi)
            begin
                return hi;
            end
            if (v < lo)
            begin
                return lo;
            end
            return v;
        endfunction

        function void set_reg(logic [IDX_BITS-1:0] idx, logic [CFG_BITS-1:0] val);
            case (idx)
                REG_GAIN_P:      kp = gain_t'(val);
                REG_GAIN_I:      ki = gain_t'(val);
                REG_GAIN_D:      kd = gain_t'(val);
                REG_PWM_CEILING: ceiling = pwm_t'(val);
                REG_PWM_FLOOR:   floor_lvl = pwm_t'(val);
                default:         ;
            endcase
        endfunction

        function pwm_t lane_step(int w, longint tgt, longint meas);
            longint e;
            longint p1;
            longint p2;
            longint sum;
            longint top;
            longint level;
            e = clamp_signed(tgt - meas, ERR_BITS);
            p1 = e_last[w];
            p2 = e_prev[w];
            sum = longint'(acc[w]) + longint'(kp) * (e - p1) + longint'(ki) * e
                + longint'(kd) * (e - 2 * p1 + p2);
            top = longint'(ceiling) << GAIN_FRAC_BITS;
            if (sum > top)
            begin
                sum = top;
            end
            if (sum < 0)
            begin
                sum = 0;
            end
            acc[w] = acc_t'(sum);
            e_prev[w] = e_last[w];
            e_last[w] = err_t'(e);
            level = sum >>> GAIN_FRAC_BITS;
            if (level > 0 && level < longint'(floor_lvl))
            begin
                level = longint'(floor_lvl);
            end
            return pwm_t'(level);
        endfunction

        function void note_tick(speed_t t, speed_t l, speed_t r);
            longint tg;
            longint ls;
            longint rs;
            longint adj;
            tg = clamp_signed(t, SPEED_BITS);
            ls = clamp_signed(l, SPEED_BITS);
            rs = clamp_signed(r, SPEED_BITS);
            adj = (ls - rs) / SYNC_DIV;
            due_left.push_back(lane_step(0, clamp_signed(tg - adj, SPEED_BITS), ls));
            due_right.push_back(lane_step(1, clamp_signed(tg + adj, SPEED_BITS), rs));
            ticks++;
        endfunction

        function void check_pwm(pwm_t l, pwm_t r);
            pwm_t want_l;
            pwm_t want_r;
            if (due_left.size() == 0)
            begin
                $display("%0t: unexpected transaction, expected none, %s %0d %0d",
                         $time, "actual pwm_left and pwm_right", l, r);
                mismatches++;
                return;
            end
            want_l = due_left.pop_front();
            want_r = due_right.pop_front();
            checked++;
            if (l !== want_l)
            begin
                $display("%0t: pwm_left expected %0d, actual %0d", $time, want_l, l);
                mismatches++;
            end
            if (r !== want_r)
            begin
                $display("%0t: pwm_right expected %0d, actual %0d", $time, want_r, r);
                mismatches++;
            end
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n;
    logic                cfg_wr_en;
    logic [IDX_BITS-1:0] cfg_index;
    logic [CFG_BITS-1:0] cfg_data;
    logic                in_valid;
    logic                in_stall;
    speed_t              speed_setpoint;
    speed_t              left_speed;
    speed_t              right_speed;
    logic                out_valid;
    logic                out_stall = 1'b0;
    pwm_t                pwm_left;
    pwm_t                pwm_right;

    pwm_tracker books;
    int         tx_idle_pct;
    int         rx_idle_pct;
    logic       hold_req;
    int         hold_count = 0;
    int         quiet_cycles = 0;
    int         settings_used = 0;

    int probe [PROBE_COUNT][3] = '{
        '{0, 0, 0},
        '{100, 90, 95},
        '{100, 103, 98},
        '{100, 98, 103},
        '{50, 48, 51},
        '{32767, 32767, -32768},
        '{-32768, -32768, 32767},
        '{32767, -32768, -32768},
        '{-32768, 32767, 32767},
        '{-32768, -32768, -32768},
        '{32767, 32767, 32767},
        '{1000, 0, 0},
        '{1000, 500, 480},
        '{1000, 1000, 1000},
        '{0, 1000, 1000},
        '{-1, -1, 0},
        '{21845, -21846, 10922},
        '{-21846, 21845, -10923},
        '{200, 150, 160},
        '{200, 200, 200}
    };

    dual_wheel_incremental_pid_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .speed_setpoint (speed_setpoint),
        .left_speed     (left_speed),
        .right_speed    (right_speed),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .pwm_left       (pwm_left),
        .pwm_right      (pwm_right)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (hold_req && hold_count < LONG_HOLD)
        begin
            out_stall <= 1'b1;
            hold_count <= hold_count + 1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < rx_idle_pct);
            if (!hold_req)
            begin
                hold_count <= 0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                books.note_tick(speed_setpoint, left_speed, right_speed);
            end
            if (out_valid && !out_stall)
            begin
                books.check_pwm(pwm_left, pwm_right);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic speed_t corner_speed();
        speed_t v;
        case ($urandom_range(3))
            0:       v = SPEED_TOP;
            1:       v = SPEED_BOTTOM;
            2:       v = '0;
            default: v = '1;
        endcase
        return v;
    endfunction

    task automatic send_tick(speed_t t, speed_t l, speed_t r);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        speed_setpoint <= t;
        left_speed <= l;
        right_speed <= r;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
    endtask

    task automatic send_random(int count);
        int     cruise;
        int     bias;
        int     run_left;
        int     pick;
        speed_t t;
        speed_t l;
        speed_t r;
        cruise = 0;
        bias = 0;
        run_left = 0;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(99);
            if (pick < 70)
            begin
                if (run_left == 0)
                begin
                    cruise = int'($urandom_range(6000)) - 3000;
                    bias = int'($urandom_range(600)) - 300;
                    run_left = $urandom_range(16, 6);
                end
                run_left--;
                t = speed_t'(cruise);
                l = speed_t'(cruise - bias + int'($urandom_range(300)) - 150);
                r = speed_t'(cruise - bias + int'($urandom_range(300)) - 150);
            end
            else if (pick < 85)
            begin
                t = speed_t'($urandom);
                l = speed_t'($urandom);
                r = speed_t'($urandom);
            end
            else
            begin
                t = corner_speed();
                l = corner_speed();
                r = corner_speed();
            end
            send_tick(t, l, r);
        end
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (books.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (PIPE_SLACK) @(posedge clk);
    endtask

    task automatic put_reg(logic [IDX_BITS-1:0] idx, logic [CFG_BITS-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        books.set_reg(idx, val);
    endtask

    task automatic program_regs(logic [CFG_BITS-1:0] p, logic [CFG_BITS-1:0] i,
                                logic [CFG_BITS-1:0] d, logic [CFG_BITS-1:0] ceil_w,
                                logic [CFG_BITS-1:0] floor_w);
        put_reg(REG_GAIN_P, p);
        put_reg(REG_GAIN_I, i);
        put_reg(REG_GAIN_D, d);
        put_reg(REG_PWM_CEILING, ceil_w);
        put_reg(REG_PWM_FLOOR, floor_w);
        for (int k = FIRST_UNUSED_REG; k < (1 << IDX_BITS); k++)
        begin
            put_reg(IDX_BITS'(k), CFG_BITS'($urandom));
        end
        cfg_wr_en <= 1'b0;
        @(posedge clk);
        settings_used++;
    endtask

    initial
    begin
        books = new();
        rst_n <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        in_valid <= 1'b0;
        speed_setpoint <= '0;
        left_speed <= '0;
        right_speed <= '0;
        hold_req <= 1'b0;
        tx_idle_pct <= 11;
        rx_idle_pct <= 50;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int k = 0; k < PROBE_COUNT; k++)
        begin
            send_tick(speed_t'(probe[k][0]), speed_t'(probe[k][1]), speed_t'(probe[k][2]));
        end
        settle();

        program_regs(16'd6144, 16'd512, 16'd256, 16'd1500, 16'd40);
        send_random(130);

        hold_req <= 1'b1;
        send_random(24);
        settle();
        hold_req <= 1'b0;

        program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hF800);
        send_random(40);
        settle();

        program_regs(16'd0, 16'd4096, 16'd0, 16'd1, 16'd0);
        send_random(25);
        settle();

        tx_idle_pct <= 50;
        rx_idle_pct <= 11;
        program_regs(16'd4096, 16'd328, 16'd205, 16'd0, 16'd30);
        send_random(30);
        settle();

        program_regs(16'd8192, 16'd600, 16'd300, 16'd120, 16'h07FF);
        send_random(40);
        settle();

        program_regs(CFG_BITS'($urandom_range(8192, 1024)), CFG_BITS'($urandom_range(1024)),
                     CFG_BITS'($urandom_range(1024)), CFG_BITS'($urandom_range(2047, 100)),
                     CFG_BITS'($urandom_range(200)));
        send_random(130);
        settle();

        tx_idle_pct <= 0;
        rx_idle_pct <= 0;
        program_regs(CFG_BITS'($urandom_range(8192, 1024)), CFG_BITS'($urandom_range(1024)),
                     CFG_BITS'($urandom_range(1024)), CFG_BITS'($urandom_range(2047, 100)),
                     CFG_BITS'($urandom_range(200)));
        send_random(120);
        settle();

        $display("Summary: %0d control ticks driven, %0d results checked, %0d settings.",
                 books.ticks, books.checked, settings_used);
        $display("Covered speed corners, unit and zero ceilings, %s",
                 "a floor above the ceiling and a long output hold-off.");
        if (books.mismatches == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ----- dual_wheel_incremental_pid_unit.f -----
+incdir+rtl
rtl/dwip_pkg.sv
rtl/dwip_sync.sv
rtl/dwip_lane.sv
rtl/dual_wheel_incremental_pid_unit.sv
tb/sv/tb_top.sv
